// ----- hw/rtl/pcd_pkg.sv -----
`default_nettype none

package pcd_pkg;

    localparam int MAX_CHUNKS = 6;
    localparam int SKIP_CHARS = 2;
    localparam int SUM_W      = 32;
    localparam int CHUNK_W    = 5;
    localparam int CHAR_W     = 8;
    localparam int COORD_W    = 32;
    localparam int VAL_W      = MAX_CHUNKS * CHUNK_W;
    localparam int CNT_MAX    = (MAX_CHUNKS > SKIP_CHARS) ? MAX_CHUNKS : SKIP_CHARS;
    localparam int CNT_W      = $clog2(CNT_MAX + 1);
    localparam int EXT_W      = ((SUM_W > VAL_W) ? SUM_W : VAL_W) + 1;
    localparam int OX_W       = (SUM_W > COORD_W) ? SUM_W : COORD_W;

    localparam logic [CHAR_W-1:0] CHAR_BIAS = CHAR_W'(63);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_REF_LAT,
        PH_REF_LNG,
        PH_DLAT,
        PH_DLNG
    } t_phase;

    localparam t_phase PH_RESET = (SKIP_CHARS > 0) ? PH_SKIP : PH_REF_LAT;

    typedef struct packed {
        logic [CHAR_W-1:0] code_char;
        logic              end_of_string;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] latitude;
        logic signed [COORD_W-1:0] longitude;
        logic                      final_point;
    } t_out;

    // one completed value from the character decoder
    typedef struct packed {
        logic                    done;
        logic                    last;
        t_phase                  phase;
        logic signed [VAL_W-1:0] value;
    } t_evt;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [VAL_W-1:0] d
    );
        logic signed [EXT_W-1:0] s;
        s = EXT_W'(a) + EXT_W'(d);
        if (s > EXT_W'(SUM_MAX)) begin
            return SUM_MAX;
        end else if (s < EXT_W'(SUM_MIN)) begin
            return SUM_MIN;
        end else begin
            return s[SUM_W-1:0];
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] to_coord(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [OX_W-1:0] t;
        t = OX_W'(s);
        return t[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcd_char_fsm.sv -----
`default_nettype none

module pcd_char_fsm (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_adv,
    input  wire pcd_pkg::t_in i_word,
    output pcd_pkg::t_evt     o_evt
);

    pcd_pkg::t_phase r_phase, n_phase;
    logic [pcd_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [pcd_pkg::VAL_W-1:0]   r_part, n_part;

    logic [pcd_pkg::CHAR_W-1:0]  w_diff;
    logic [pcd_pkg::CHUNK_W:0]   w_grp;
    logic [pcd_pkg::VAL_W-1:0]   w_raw;
    logic [pcd_pkg::VAL_W-1:0]   w_mag;
    logic [pcd_pkg::CNT_W-1:0]   w_idx_inc;
    logic                        w_done;
    logic                        w_skip_end;
    logic                        w_eos;

    assign w_eos      = i_word.end_of_string;
    assign w_diff     = i_word.code_char - pcd_pkg::CHAR_BIAS;
    assign w_grp      = w_diff[pcd_pkg::CHUNK_W:0];
    assign w_idx_inc  = r_idx + pcd_pkg::CNT_W'(1);
    assign w_skip_end = (w_idx_inc >= pcd_pkg::CNT_W'(pcd_pkg::SKIP_CHARS));
    assign w_done     = !w_grp[pcd_pkg::CHUNK_W]
                     || (r_idx == pcd_pkg::CNT_W'(pcd_pkg::MAX_CHUNKS - 1))
                     || w_eos;

    // slots above the current chunk are still zero, so placing the chunk is the OR
    always_comb begin
        w_raw = r_part;
        for (int k = 0; k < pcd_pkg::MAX_CHUNKS; k++) begin
            if (r_idx == pcd_pkg::CNT_W'(k)) begin
                w_raw[k*pcd_pkg::CHUNK_W +: pcd_pkg::CHUNK_W] = w_grp[pcd_pkg::CHUNK_W-1:0];
            end
        end
    end

    assign w_mag = {1'b0, w_raw[pcd_pkg::VAL_W-1:1]};

    always_comb begin
        n_phase = r_phase;
        if (i_adv) begin
            if (w_eos) begin
                n_phase = pcd_pkg::PH_RESET;
            end else begin
                unique case (r_phase)
                    pcd_pkg::PH_SKIP:    if (w_skip_end) n_phase = pcd_pkg::PH_REF_LAT;
                    pcd_pkg::PH_REF_LAT: if (w_done) n_phase = pcd_pkg::PH_REF_LNG;
                    pcd_pkg::PH_REF_LNG: if (w_done) n_phase = pcd_pkg::PH_DLAT;
                    pcd_pkg::PH_DLAT:    if (w_done) n_phase = pcd_pkg::PH_DLNG;
                    pcd_pkg::PH_DLNG:    if (w_done) n_phase = pcd_pkg::PH_DLAT;
                    default:             n_phase = pcd_pkg::PH_RESET;
                endcase
            end
        end
    end

    always_comb begin
        n_idx       = r_idx;
        n_part      = r_part;
        o_evt.done  = 1'b0;
        o_evt.last  = w_eos;
        o_evt.phase = r_phase;
        o_evt.value = w_raw[0] ? ~w_mag : w_mag;
        if (i_adv) begin
            if (r_phase == pcd_pkg::PH_SKIP) begin
                n_idx = (w_eos || w_skip_end) ? '0 : w_idx_inc;
            end else begin
                o_evt.done = w_done;
                if (w_done) begin
                    n_idx  = '0;
                    n_part = '0;
                end else begin
                    n_idx  = w_idx_inc;
                    n_part = w_raw;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcd_pkg::PH_RESET;
            r_idx   <= '0;
            r_part  <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_part  <= n_part;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/polyline_coordinate_decoder_unit.sv -----
`default_nettype none

// Channel  Valid         Ready         Word
// input    i_in_valid    o_in_ready    i_in_word  (code_char, end_of_string)
// output   o_out_valid   i_out_ready   o_out_word (latitude, longitude, final_point)
//
// One character per cycle while the output side does not stall. A word lands in the
// input register, is decoded and summed when it advances, and a completed point is
// visible in the cycle after. A full output register that is not being taken holds
// the input register, which takes a new word whenever it is empty or moving on.
// Synchronous active-low reset returns to the skip phase; no clearing pass.

module polyline_coordinate_decoder_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pcd_pkg::t_in  i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pcd_pkg::t_out      o_out_word
);

    logic                             r_in_valid;
    pcd_pkg::t_in                     r_in;
    logic                             r_out_valid;
    pcd_pkg::t_out                    r_out, n_out;
    logic signed [pcd_pkg::SUM_W-1:0] r_lat, r_lng;

    logic                             w_adv;
    logic                             w_in_acc;
    pcd_pkg::t_evt                    w_evt;
    logic                             w_lat_side;
    logic                             w_lng_side;
    logic                             w_ref;
    logic                             w_emit;
    logic signed [pcd_pkg::SUM_W-1:0] w_base;
    logic signed [pcd_pkg::SUM_W-1:0] w_sum;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    pcd_char_fsm u_char_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_word  (r_in),
        .o_evt   (w_evt)
    );

    always_comb begin
        w_lat_side = (w_evt.phase == pcd_pkg::PH_REF_LAT) || (w_evt.phase == pcd_pkg::PH_DLAT);
        w_lng_side = (w_evt.phase == pcd_pkg::PH_REF_LNG) || (w_evt.phase == pcd_pkg::PH_DLNG);
        w_ref      = (w_evt.phase == pcd_pkg::PH_REF_LAT) || (w_evt.phase == pcd_pkg::PH_REF_LNG);
        w_base     = w_ref ? '0 : (w_lat_side ? r_lat : r_lng);
        w_sum      = pcd_pkg::sat_add(w_base, w_evt.value);
        w_emit     = w_evt.done && ((w_evt.phase == pcd_pkg::PH_DLNG)
                  || ((w_evt.phase == pcd_pkg::PH_DLAT) && w_evt.last));
        n_out.latitude    = pcd_pkg::to_coord(w_lat_side ? w_sum : r_lat);
        n_out.longitude   = pcd_pkg::to_coord(w_lng_side ? w_sum : r_lng);
        n_out.final_point = w_evt.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_word;
        end
        if (w_evt.done && w_lat_side) begin
            r_lat <= w_sum;
        end
        if (w_evt.done && w_lng_side) begin
            r_lng <= w_sum;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/pcd_checker.sv -----
`default_nettype none

module pcd_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire pcd_pkg::t_in  i_in_word,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire pcd_pkg::t_out o_out_word
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid straight after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");

    a_final_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_word.final_point |=> !o_out_valid)
        else $error("point emitted right after the closing point");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word dropped or changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))
        else $error("waiting input word dropped or changed");

endmodule

bind polyline_coordinate_decoder_unit pcd_checker u_pcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
